[design/fgpid_pkg.sv]
// ----------------------------------------------------------------------------
// fgpid_pkg
// Types, rule tables and helper functions of the fuzzy gain PID controller.
// ----------------------------------------------------------------------------
package fgpid_pkg;

  localparam int RuleLevels = 7;
  localparam int RuleCells  = RuleLevels * RuleLevels;
  localparam int IdxW       = $clog2(RuleLevels);
  localparam int CellW      = $clog2(RuleCells);

  // Configuration register indexes.
  localparam logic [3:0] CfgKpBase   = 4'd0;
  localparam logic [3:0] CfgKiBase   = 4'd1;
  localparam logic [3:0] CfgKdBase   = 4'd2;
  localparam logic [3:0] CfgSteps    = 4'd3;
  localparam logic [3:0] CfgScale    = 4'd4;
  localparam logic [3:0] CfgDeadband = 4'd5;
  localparam logic [3:0] CfgThresh   = 4'd6;
  localparam logic [3:0] CfgLimits   = 4'd7;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StDiv
  } state_e;

  typedef enum logic [4:0] {
    StepEx,
    StepEcx,
    StepFuzzEc,
    StepW00,
    StepW01,
    StepW10,
    StepW11,
    StepWCap,
    StepSums,
    StepKp,
    StepKi,
    StepKd,
    StepPt,
    StepDec,
    StepFdt,
    StepDfc,
    StepIw,
    StepDcap,
    StepInteg,
    StepIt,
    StepIcap,
    StepFin
  } step_e;

  typedef struct packed {
    logic [IdxW-1:0] idx_l;
    logic [IdxW-1:0] idx_r;
    logic [8:0]      w_l;
    logic [8:0]      w_r;
  } fuzz_t;

  // Rule tables, row = error level, column = error change level.
  localparam logic signed [2:0] TabP [RuleCells] = '{
     3,  3,  2,  2,  1,  0,  0,
     3,  3,  2,  1,  1,  0, -1,
     2,  2,  2,  1,  0, -1, -1,
     2,  2,  1,  0, -1, -2, -2,
     1,  1,  0, -1, -1, -2, -2,
     1,  0, -1, -2, -2, -2, -3,
     0,  0, -2, -2, -2, -3, -3};
  localparam logic signed [2:0] TabI [RuleCells] = '{
    -3, -3, -2, -2, -1,  0,  0,
    -3, -3, -2, -1, -1,  0,  0,
    -3, -2, -1, -1,  0,  1,  1,
    -2, -2, -1,  0,  1,  2,  2,
    -1, -1,  0,  1,  1,  2,  3,
     0,  0,  1,  1,  2,  3,  3,
     0,  0,  1,  2,  2,  3,  3};
  localparam logic signed [2:0] TabD [RuleCells] = '{
     1, -1, -3, -3, -3, -2,  1,
     1, -1, -3, -2, -2, -1,  0,
     0, -1, -2, -2, -1, -1,  0,
     0, -1, -1, -1, -1, -1,  0,
     0,  0,  0,  0,  0,  0,  0,
     3, -1,  1,  1,  1,  1,  3,
     3,  2,  2,  2,  1,  1,  3};

  // Position in rule units (Q.8) to two neighboring levels and their weights.
  function automatic fuzz_t fuzzify(input logic signed [24:0] x);
    fuzz_t f;
    if (x >= 25'sd768) begin
      f.idx_l = IdxW'(RuleLevels - 1);
      f.idx_r = IdxW'(RuleLevels - 1);
      f.w_l   = 9'd256;
      f.w_r   = 9'd0;
    end else if (x < -25'sd768) begin
      f.idx_l = '0;
      f.idx_r = '0;
      f.w_l   = 9'd0;
      f.w_r   = 9'd256;
    end else begin
      f.idx_l = IdxW'(x[10:8] + 3'd3);
      f.idx_r = IdxW'(x[10:8] + 3'd4);
      f.w_r   = {1'b0, x[7:0]};
      f.w_l   = 9'd256 - {1'b0, x[7:0]};
    end
    return f;
  endfunction

  function automatic logic [CellW-1:0] cell_idx(input logic [IdxW-1:0] r,
                                                input logic [IdxW-1:0] c);
    return CellW'({r, 3'b000} - {3'b000, r} + {3'b000, c});
  endfunction

  function automatic logic signed [18:0] weigh(input logic [16:0] w,
                                               input logic signed [2:0] t);
    logic signed [20:0] prod;
    prod = $signed({1'b0, w}) * t;
    return prod[18:0];
  endfunction

endpackage

[design/fuzzy_gain_pid_controller.sv]
// ----------------------------------------------------------------------------
// fuzzy_gain_pid_controller
// Fuzzy self-tuning PID: 7x7 rule interpolation adjusts Kp, Ki and Kd per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  setpoint_i, measured_i
// out       output     out_valid_o/out_stall_i drive_o, output_saturated_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item runs the single shared multiplier through 22 steps, plus the
// radix-2 divider when the error lies between the integration thresholds.
// No new item is taken before the last result enters the output register.
// Reset restores configuration defaults and clears the sequencer, integral
// sum, filtered derivative, previous error and valid, but not the datapath.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only its own result waits for the register to drain.
module fuzzy_gain_pid_controller
  import fgpid_pkg::*;
#(
  parameter int FILTER_COEF = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measured_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_o,
  output logic               output_saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  localparam logic signed [9:0] FcS   = 10'(FILTER_COEF);
  localparam logic signed [9:0] FcRem = 10'(256 - FILTER_COEF);

  // Configuration.
  logic [15:0] kp_base_q, ki_base_q, kd_base_q, scale_q;
  logic [47:0] steps_q, limits_q;
  logic [14:0] deadband_q;
  logic [31:0] thresh_q;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic signed [15:0] prev_q, e_q, ec_q, acc_q;
  logic        [15:0] ae_q;
  logic               full_q, mid_q;
  logic signed [31:0] isum_q, fd_q, d_q;
  fuzz_t              fe_q, fc_q;
  logic        [16:0] w_q [4];
  logic signed [18:0] sp_q, si_q, sd_q;
  logic signed [19:0] kp_q, ki_q, kd_q;
  logic signed [35:0] p_q, kdec_q;
  logic signed [40:0] fdt_q;
  logic signed [44:0] dfc_q;
  logic signed [51:0] i_q;
  logic               neg_q;
  logic        [31:0] quo_q;
  logic        [15:0] rem_q;
  logic        [4:0]  div_cnt_q;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod_q;

  logic               out_valid_q, sat_q;
  logic signed [15:0] drive_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o         = (state_q != StIdle);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign drive_o            = drive_q;
  assign output_saturated_o = sat_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_base_q  <= 16'd256;
      ki_base_q  <= 16'd0;
      kd_base_q  <= 16'd0;
      steps_q    <= 48'd0;
      scale_q    <= 16'd256;
      deadband_q <= 15'd0;
      thresh_q   <= 32'h7FFF_7FFF;
      limits_q   <= 48'h7FFF_7FFF_FFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgKpBase:   kp_base_q  <= cfg_data_i[15:0];
        CfgKiBase:   ki_base_q  <= cfg_data_i[15:0];
        CfgKdBase:   kd_base_q  <= cfg_data_i[15:0];
        CfgSteps:    steps_q    <= cfg_data_i;
        CfgScale:    scale_q    <= cfg_data_i[15:0];
        CfgDeadband: deadband_q <= cfg_data_i[14:0];
        CfgThresh:   thresh_q   <= cfg_data_i[31:0];
        CfgLimits:   limits_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input conditioning at acceptance.
  logic signed [16:0] e_raw, ec_raw, acc_raw;
  logic signed [15:0] e_sat, e_new, ec_new;
  logic        [15:0] ae_raw, ae_new;
  always_comb begin
    e_raw = 17'(setpoint_i) - 17'(measured_i);
    if (e_raw > 17'sd32767) begin
      e_sat = 16'sh7FFF;
    end else if (e_raw < -17'sd32768) begin
      e_sat = 16'sh8000;
    end else begin
      e_sat = e_raw[15:0];
    end
    ae_raw = e_sat[15] ? 16'(-17'(e_sat)) : e_sat;
    if (ae_raw < {1'b0, deadband_q}) begin
      e_new  = '0;
      ae_new = '0;
    end else begin
      e_new  = e_sat;
      ae_new = ae_raw;
    end
    ec_raw = 17'(e_new) - 17'(prev_q);
    if (ec_raw > 17'sd32767) begin
      ec_new = 16'sh7FFF;
    end else if (ec_raw < -17'sd32768) begin
      ec_new = 16'sh8000;
    end else begin
      ec_new = ec_raw[15:0];
    end
    acc_raw = 17'(e_new) + 17'(prev_q);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepEx;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StCalc;
          step_d  = StepEx;
        end
      end
      StCalc: begin
        priority if (step_q == StepFin) begin
          if (out_free) begin
            state_d = StIdle;
          end
        end else if (step_q == StepDcap && mid_q) begin
          state_d = StDiv;
          step_d  = StepInteg;
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      StDiv: begin
        if (div_cnt_q == 5'd31) begin
          state_d = StCalc;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      StepEx:  begin mul_a = 36'(e_q);  mul_b = {17'd0, scale_q}; end
      StepEcx: begin mul_a = 36'(ec_q); mul_b = {17'd0, scale_q}; end
      StepW00: begin mul_a = {27'd0, fe_q.w_l}; mul_b = {24'd0, fc_q.w_l}; end
      StepW01: begin mul_a = {27'd0, fe_q.w_l}; mul_b = {24'd0, fc_q.w_r}; end
      StepW10: begin mul_a = {27'd0, fe_q.w_r}; mul_b = {24'd0, fc_q.w_l}; end
      StepW11: begin mul_a = {27'd0, fe_q.w_r}; mul_b = {24'd0, fc_q.w_r}; end
      StepKp:  begin mul_a = 36'(sp_q); mul_b = {17'd0, steps_q[15:0]}; end
      StepKi:  begin mul_a = 36'(si_q); mul_b = {17'd0, steps_q[31:16]}; end
      StepKd:  begin mul_a = 36'(sd_q); mul_b = {17'd0, steps_q[47:32]}; end
      StepPt:  begin mul_a = 36'(kp_q); mul_b = 33'(e_q); end
      StepDec: begin mul_a = 36'(kd_q); mul_b = 33'(ec_q); end
      StepFdt: begin mul_a = 36'(fd_q); mul_b = 33'(FcRem); end
      StepDfc: begin mul_a = kdec_q;    mul_b = 33'(FcS); end
      StepIw: begin
        mul_a = 36'(acc_q);
        mul_b = 33'({1'b0, thresh_q[31:16]}) - 33'({1'b0, ae_q});
      end
      StepIt:  begin mul_a = 36'(ki_q); mul_b = 33'(isum_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Derivative from the two partial products, saturated to 32 bits.
  logic signed [45:0] dsum;
  logic signed [37:0] dsh;
  logic signed [31:0] d_new;
  always_comb begin
    dsum = 46'(dfc_q) + 46'(fdt_q);
    dsh  = dsum[45:8];
    if (dsh > 38'sh7FFF_FFFF) begin
      d_new = 32'sh7FFF_FFFF;
    end else if (dsh < -38'sh8000_0000) begin
      d_new = 32'sh8000_0000;
    end else begin
      d_new = dsh[31:0];
    end
  end

  // Datapath captures.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q    <= e_new;
      ec_q   <= ec_new;
      ae_q   <= ae_new;
      acc_q  <= acc_raw[16:1];
      full_q <= ae_new < thresh_q[15:0];
      mid_q  <= !(ae_new < thresh_q[15:0]) && (ae_new < thresh_q[31:16]);
    end
    if (state_q == StCalc) begin
      unique case (step_q)
        StepEcx:    fe_q   <= fuzzify(prod_q[32:8]);
        StepFuzzEc: fc_q   <= fuzzify(prod_q[32:8]);
        StepW01:    w_q[0] <= prod_q[16:0];
        StepW10:    w_q[1] <= prod_q[16:0];
        StepW11:    w_q[2] <= prod_q[16:0];
        StepWCap:   w_q[3] <= prod_q[16:0];
        StepSums: begin
          sp_q <= weigh(w_q[0], TabP[cell_idx(fe_q.idx_l, fc_q.idx_l)])
                + weigh(w_q[1], TabP[cell_idx(fe_q.idx_l, fc_q.idx_r)])
                + weigh(w_q[2], TabP[cell_idx(fe_q.idx_r, fc_q.idx_l)])
                + weigh(w_q[3], TabP[cell_idx(fe_q.idx_r, fc_q.idx_r)]);
          si_q <= weigh(w_q[0], TabI[cell_idx(fe_q.idx_l, fc_q.idx_l)])
                + weigh(w_q[1], TabI[cell_idx(fe_q.idx_l, fc_q.idx_r)])
                + weigh(w_q[2], TabI[cell_idx(fe_q.idx_r, fc_q.idx_l)])
                + weigh(w_q[3], TabI[cell_idx(fe_q.idx_r, fc_q.idx_r)]);
          sd_q <= weigh(w_q[0], TabD[cell_idx(fe_q.idx_l, fc_q.idx_l)])
                + weigh(w_q[1], TabD[cell_idx(fe_q.idx_l, fc_q.idx_r)])
                + weigh(w_q[2], TabD[cell_idx(fe_q.idx_r, fc_q.idx_l)])
                + weigh(w_q[3], TabD[cell_idx(fe_q.idx_r, fc_q.idx_r)]);
        end
        StepKi:  kp_q   <= 20'($signed({1'b0, kp_base_q})) + 20'($signed(prod_q[34:16]));
        StepKd:  ki_q   <= 20'($signed({1'b0, ki_base_q})) + 20'($signed(prod_q[34:16]));
        StepPt:  kd_q   <= 20'($signed({1'b0, kd_base_q})) + 20'($signed(prod_q[34:16]));
        StepDec: p_q    <= prod_q[35:0];
        StepFdt: kdec_q <= prod_q[35:0];
        StepDfc: fdt_q  <= prod_q[40:0];
        StepIw:  dfc_q  <= prod_q[44:0];
        StepDcap: begin
          d_q   <= d_new;
          neg_q <= prod_q[32];
          quo_q <= prod_q[32] ? 32'(-prod_q[32:0]) : prod_q[31:0];
          rem_q <= '0;
        end
        StepIcap: i_q <= prod_q[51:0];
        default: ;
      endcase
    end else if (state_q == StDiv) begin
      // One quotient bit per cycle, restoring.
      if ({rem_q, quo_q[31]} >= {1'b0, thresh_q[31:16] - thresh_q[15:0]}) begin
        rem_q <= 16'({rem_q, quo_q[31]} - {1'b0, thresh_q[31:16] - thresh_q[15:0]});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == StDiv) begin
      div_cnt_q <= div_cnt_q + 5'd1;
    end else begin
      div_cnt_q <= '0;
    end
  end

  // Integral update with the average error (full zone) or floor quotient, and clamp.
  logic signed [32:0] lim_s, quot_s, inc;
  logic signed [33:0] isum_new;
  always_comb begin
    lim_s  = limits_q[31] ? 33'sh0_7FFF_FFFF : {1'b0, limits_q[31:0]};
    quot_s = neg_q ? -(33'({1'b0, quo_q}) + 33'(rem_q != '0)) : 33'({1'b0, quo_q});
    inc    = full_q ? 33'(acc_q) : quot_s;
    isum_new = 34'(isum_q) + 34'(inc);
    if (isum_new > 34'(lim_s)) begin
      isum_new = 34'(lim_s);
    end else if (isum_new < -34'(lim_s)) begin
      isum_new = -34'(lim_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
      fd_q   <= '0;
      prev_q <= '0;
    end else if (state_q == StCalc && step_q == StepInteg) begin
      if (full_q || mid_q) begin
        isum_q <= isum_new[31:0];
      end
      fd_q   <= d_q;
      prev_q <= e_q;
    end
  end

  // Output sum, scaling and saturation.
  logic signed [53:0] tot;
  logic signed [45:0] v, olim, c1, c2;
  always_comb begin
    tot  = 54'(p_q) + 54'(i_q) + 54'(d_q);
    v    = tot[53:8];
    olim = {30'd0, limits_q[47:32]};
    if (v > olim) begin
      c1 = olim;
    end else if (v < -olim) begin
      c1 = -olim;
    end else begin
      c1 = v;
    end
    if (c1 > 46'sd32767) begin
      c2 = 46'sd32767;
    end else if (c1 < -46'sd32768) begin
      c2 = -46'sd32768;
    end else begin
      c2 = c1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StCalc && step_q == StepFin && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StCalc && step_q == StepFin && out_free) begin
      drive_q <= c2[15:0];
      sat_q   <= (c2 != v);
    end
  end

  // Checks.
  a_div_only_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> mid_q)
    else $error("divider running outside the weighted integration zone");

  a_isum_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc && step_q == StepInteg && (full_q || mid_q)) |=>
      ($signed({isum_q[31], isum_q}) <= lim_s &&
       $signed({isum_q[31], isum_q}) >= -lim_s))
    else $error("integral sum outside its clamp");

  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (17'(drive_q) <= $signed({1'b0, limits_q[47:32]}) &&
                     17'(drive_q) >= -$signed({1'b0, limits_q[47:32]})))
    else $error("drive exceeds output clamp");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StDiv) |=> (div_cnt_q == 5'd0) || (state_q == StDiv))
    else $error("divider count left running");

endmodule
